// File: rtl/core/online_grid_island_counter_defines.svh
// Assertion macros for the online grid island counter.
// Depends on nothing; included by the top level only.
`ifndef ONLINE_GRID_ISLAND_COUNTER_DEFINES_SVH
`define ONLINE_GRID_ISLAND_COUNTER_DEFINES_SVH

// Implication checked on every clock, disabled in reset.
`define OGIC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OGIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ogic_pkg.sv
// Types and constants for the online grid island counter.
// No dependencies.
package ogic_pkg;

    localparam int unsigned CfgWidth   = 7;
    localparam int unsigned CountWidth = 13;
    localparam logic [CountWidth-1:0] CountMax = '1;

    localparam logic CfgRows = 1'b0;
    localparam logic CfgCols = 1'b1;

    typedef struct packed {
        logic [5:0] cell_row;
        logic [5:0] cell_col;
    } cell_req_t;

    typedef struct packed {
        logic [CountWidth-1:0] islands;
        logic                  bad_position;
    } island_rsp_t;

endpackage

// File: rtl/core/ogic_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ogic_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/online_grid_island_counter.sv
// Online grid island counter: land map plus union-find forest in RAMs.
// A bad position or a repeated cell is answered without touching the forest; a new
// cell is marked land, then each neighbor is probed: off grid is skipped, water is
// read and skipped, land finds both roots, links them if apart (path halving over RAM).
// Throughput: one request at a time; ready returns the cycle after the response is taken.
// Reset: control and count clear at once, then a clearing pass writes water
// to all MAX_ROWS*MAX_COLS land map entries, one per cycle, before any request.
`include "online_grid_island_counter_defines.svh"

module online_grid_island_counter #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ogic_pkg::CfgWidth-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ogic_pkg::cell_req_t        in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ogic_pkg::island_rsp_t      out_data
);

    import ogic_pkg::*;

    localparam int unsigned CellCount = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW        = (CellCount > 1) ? $clog2(CellCount) : 1;
    localparam int unsigned SW        = AW + 1;
    localparam int unsigned RowsW     = $clog2(MAX_ROWS + 1);
    localparam int unsigned ColsW     = $clog2(MAX_COLS + 1);
    localparam int unsigned PW        = AW + ColsW + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MUL, S_LRD, S_LCHK, S_INIT, S_NSEL, S_NRD, S_NCHK,
        S_FSTART, S_FRD1, S_FRD2, S_FRD3, S_FSTEP, S_ROOTS, S_SZRD, S_SZWAIT,
        S_SZCMP, S_LINK, S_RESP
    } state_t;

    state_t state_reg;
    logic [CfgWidth-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [CountWidth:0] total_reg;
    logic [AW-1:0]       clr_reg, idx_reg, node_reg, up_reg, ra_reg, rb_reg, nb_reg;
    logic [2:0]          nsel_reg;
    logic                which_reg;   // 0: walking from new cell, 1: from neighbor
    logic                bad_reg;
    logic [5:0]          r_reg, c_reg;
    logic [RowsW-1:0]    rows_reg;
    logic [ColsW-1:0]    cols_reg;
    logic [PW-1:0]       prod_reg;
    logic [SW-1:0]       sza_reg;

    // RAM ports
    logic          lm_we, lm_wd, lm_rd;
    logic [AW-1:0] lm_wa, lm_ra;
    logic          pl_we;
    logic [AW-1:0] pl_wa, pl_wd, pl_ra, pl_rd;
    logic          ts_we;
    logic [AW-1:0] ts_wa, ts_ra;
    logic [SW-1:0] ts_wd, ts_rd;

    ogic_ram #(.WIDTH(1), .DEPTH(CellCount)) u_land (
        .clk, .we(lm_we), .waddr(lm_wa), .wdata(lm_wd), .raddr(lm_ra), .rdata(lm_rd));
    ogic_ram #(.WIDTH(AW), .DEPTH(CellCount)) u_parent (
        .clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
    ogic_ram #(.WIDTH(SW), .DEPTH(CellCount)) u_size (
        .clk, .we(ts_we), .waddr(ts_wa), .wdata(ts_wd), .raddr(ts_ra), .rdata(ts_rd));

    // effective sizes
    logic [RowsW-1:0] rows_eff;
    logic [ColsW-1:0] cols_eff;
    always_comb
    begin
        rows_eff = (32'(rows_cfg_reg) > MAX_ROWS) ? RowsW'(MAX_ROWS) : RowsW'(rows_cfg_reg);
        cols_eff = (32'(cols_cfg_reg) > MAX_COLS) ? ColsW'(MAX_COLS) : ColsW'(cols_cfg_reg);
    end

    // neighbor address and eligibility for current probe
    logic [PW-1:0] nb_wide;
    logic          nb_ok;
    always_comb
    begin
        nb_wide = '0;
        nb_ok   = 1'b0;
        unique case (nsel_reg)
            3'd0:
            begin
                nb_ok   = (r_reg != '0);
                nb_wide = PW'(idx_reg) - PW'(cols_reg);
            end
            3'd1:
            begin
                nb_wide = PW'(idx_reg) + PW'(cols_reg);
                nb_ok   = (32'(r_reg) + 1 < 32'(rows_reg)) && (nb_wide < PW'(CellCount));
            end
            3'd2:
            begin
                nb_ok   = (c_reg != '0);
                nb_wide = PW'(idx_reg) - PW'(1);
            end
            3'd3:
            begin
                nb_wide = PW'(idx_reg) + PW'(1);
                nb_ok   = (32'(c_reg) + 1 < 32'(cols_reg)) && (nb_wide < PW'(CellCount));
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // RAM control
    always_comb
    begin
        lm_we = 1'b0; lm_wa = idx_reg; lm_wd = 1'b1; lm_ra = idx_reg;
        pl_we = 1'b0; pl_wa = idx_reg; pl_wd = idx_reg; pl_ra = node_reg;
        ts_we = 1'b0; ts_wa = idx_reg; ts_wd = SW'(1); ts_ra = ra_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                lm_we = 1'b1; lm_wa = clr_reg; lm_wd = 1'b0;
            end
            S_NRD:    lm_ra = nb_reg;
            S_INIT:
            begin
                lm_we = 1'b1; pl_we = 1'b1; ts_we = 1'b1;
            end
            S_FRD3:   pl_ra = up_reg;
            S_FSTEP:
            begin
                // halving: parent[node] = parent[up]
                pl_we = (up_reg != node_reg); pl_wa = node_reg; pl_wd = pl_rd;
            end
            S_SZRD:   ts_ra = ra_reg;
            S_SZWAIT: ts_ra = rb_reg;
            S_SZCMP:  ts_ra = rb_reg;
            S_LINK:
            begin
                pl_we = 1'b1; ts_we = 1'b1;
                if (sza_reg < ts_rd)
                begin
                    pl_wa = ra_reg; pl_wd = rb_reg; ts_wa = rb_reg;
                end
                else
                begin
                    pl_wa = rb_reg; pl_wd = ra_reg; ts_wa = ra_reg;
                end
                ts_wd = sza_reg + ts_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            rows_cfg_reg <= CfgWidth'(64);
            cols_cfg_reg <= CfgWidth'(64);
            total_reg    <= '0;
            clr_reg      <= '0;
            nsel_reg     <= '0;
            which_reg    <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CfgRows)
                begin
                    rows_cfg_reg <= cfg_wdata;
                end
                else
                begin
                    cols_cfg_reg <= cfg_wdata;
                end
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == CellCount - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg    <= in_data.cell_row;
                        c_reg    <= in_data.cell_col;
                        rows_reg <= rows_eff;
                        cols_reg <= cols_eff;
                        bad_reg  <= (32'(in_data.cell_row) >= 32'(rows_eff))
                                 || (32'(in_data.cell_col) >= 32'(cols_eff));
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= PW'(r_reg) * PW'(cols_reg) + PW'(c_reg);
                    state_reg <= S_LRD;
                end
                S_LRD:
                begin
                    idx_reg <= AW'(prod_reg);
                    if (bad_reg || prod_reg >= PW'(CellCount))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_LCHK;
                    end
                end
                S_LCHK:
                begin
                    // land read of idx issued on this edge
                    state_reg <= S_FRD1;
                    which_reg <= 1'b0;
                end
                S_INIT:
                begin
                    total_reg <= total_reg + 1'b1;
                    nsel_reg  <= '0;
                    state_reg <= S_NSEL;
                end
                S_NSEL:
                begin
                    if (nsel_reg == 3'd4)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (nb_ok)
                    begin
                        nb_reg    <= AW'(nb_wide);
                        state_reg <= S_NRD;
                    end
                    else
                    begin
                        nsel_reg <= nsel_reg + 3'd1;
                    end
                end
                S_NRD:    state_reg <= S_NCHK;
                S_NCHK:
                begin
                    if (lm_rd)
                    begin
                        node_reg  <= idx_reg;
                        which_reg <= 1'b0;
                        state_reg <= S_FSTART;
                    end
                    else
                    begin
                        nsel_reg  <= nsel_reg + 3'd1;
                        state_reg <= S_NSEL;
                    end
                end
                S_FSTART: state_reg <= S_FRD2;   // parent[node] read issued
                S_FRD1:
                begin
                    // idx land bit is valid here (read registered at S_LCHK)
                    if (lm_rd)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_FRD2:
                begin
                    if (pl_rd == node_reg)
                    begin
                        if (!which_reg)
                        begin
                            ra_reg    <= node_reg;
                            node_reg  <= nb_reg;
                            which_reg <= 1'b1;
                            state_reg <= S_FSTART;
                        end
                        else
                        begin
                            rb_reg    <= node_reg;
                            state_reg <= S_ROOTS;
                        end
                    end
                    else
                    begin
                        up_reg    <= pl_rd;
                        state_reg <= S_FRD3;
                    end
                end
                S_FRD3:   state_reg <= S_FSTEP;  // parent[up] read issued
                S_FSTEP:
                begin
                    node_reg  <= pl_rd;
                    state_reg <= S_FSTART;
                end
                S_ROOTS:
                begin
                    if (ra_reg == rb_reg)
                    begin
                        nsel_reg  <= nsel_reg + 3'd1;
                        state_reg <= S_NSEL;
                    end
                    else
                    begin
                        if (total_reg != '0)
                        begin
                            total_reg <= total_reg - 1'b1;
                        end
                        state_reg <= S_SZRD;
                    end
                end
                S_SZRD:   state_reg <= S_SZWAIT;
                S_SZWAIT:
                begin
                    sza_reg   <= ts_rd;
                    state_reg <= S_SZCMP;
                end
                S_SZCMP:  state_reg <= S_LINK;
                S_LINK:
                begin
                    nsel_reg  <= nsel_reg + 3'd1;
                    state_reg <= S_NSEL;
                end
                S_RESP:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    always_comb
    begin
        out_data.bad_position = bad_reg;
        out_data.islands = (total_reg > (CountWidth+1)'(CountMax))
                         ? CountMax : CountWidth'(total_reg);
    end

    `OGIC_ASSERT_IMP(a_one_side, out_valid, !in_ready, "input taken while response pending")
    `OGIC_ASSERT_NEXT(a_bad_keeps_count, out_valid && bad_reg && !out_ready,
        $stable(total_reg), "count moved on bad position")
    `OGIC_ASSERT_NEXT(a_count_step, in_valid && in_ready, total_reg == $past(total_reg),
        "count changed at request accept")

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the online grid island counter.
// Depends on ogic_pkg and the online_grid_island_counter top level.
`timescale 1ns / 1ps

module testbench;
    import ogic_pkg::*;

    localparam int unsigned GRID_MAX = 64;
    localparam int unsigned CELLS = GRID_MAX * GRID_MAX;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CfgWidth-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    cell_req_t in_data;
    logic out_valid;
    logic out_ready;
    island_rsp_t out_data;

    online_grid_island_counter #(.MAX_ROWS(GRID_MAX), .MAX_COLS(GRID_MAX)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // predictor state
    bit          is_land [CELLS];
    logic [11:0] link    [CELLS];
    int unsigned set_size[CELLS];
    int unsigned island_count;
    int unsigned rows_reg;
    int unsigned cols_reg;

    cell_req_t   pending_cells[$];
    island_rsp_t expected_counts[$];
    int          errors;
    bit          idle_off;
    bit          out_hold;
    bit          in_hold;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned find_root(int unsigned node);
        int unsigned up;
        int unsigned guard;
        guard = 0;
        while (link[node] != node && guard < CELLS)
        begin
            up = link[node];
            link[node] = link[up];
            node = link[node];
            guard++;
        end
        return node;
    endfunction

    function automatic void merge_cells(int unsigned a, int unsigned b);
        int unsigned ra;
        int unsigned rb;
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb)
            return;
        if (island_count > 0)
            island_count--;
        if (set_size[ra] < set_size[rb])
        begin
            link[ra] = rb;
            set_size[rb] += set_size[ra];
        end
        else
        begin
            link[rb] = ra;
            set_size[ra] += set_size[rb];
        end
    endfunction

    function automatic island_rsp_t add_cell(cell_req_t req);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        island_rsp_t rsp;
        rows = rows_reg > GRID_MAX ? GRID_MAX : rows_reg;
        cols = cols_reg > GRID_MAX ? GRID_MAX : cols_reg;
        r = req.cell_row;
        c = req.cell_col;
        rsp.bad_position = (r >= rows || c >= cols);
        if (!rsp.bad_position)
        begin
            idx = r * cols + c;
            if (idx < CELLS && !is_land[idx])
            begin
                is_land[idx] = 1'b1;
                link[idx] = idx;
                set_size[idx] = 1;
                island_count++;
                if (r > 0 && is_land[idx - cols])
                    merge_cells(idx, idx - cols);
                if (r + 1 < rows && idx + cols < CELLS && is_land[idx + cols])
                    merge_cells(idx, idx + cols);
                if (c > 0 && is_land[idx - 1])
                    merge_cells(idx, idx - 1);
                if (c + 1 < cols && idx + 1 < CELLS && is_land[idx + 1])
                    merge_cells(idx, idx + 1);
            end
        end
        rsp.islands = island_count > CountMax ? CountMax : island_count;
        return rsp;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_cells.size() > 0 && !in_hold
                && (idle_off || $urandom_range(99) >= 17))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_cells[0];
                expected_counts = {expected_counts, add_cell(pending_cells.pop_front())};
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, out_data);
                    errors++;
                end
                else if (out_data.islands !== expected_counts[0].islands
                    || out_data.bad_position !== expected_counts[0].bad_position)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                        expected_counts[0], out_data);
                    errors++;
                    void'(expected_counts.pop_front());
                end
                else
                    void'(expected_counts.pop_front());
            end
            out_ready <= !out_hold && (idle_off || $urandom_range(99) >= 17);
        end
    end

    task automatic write_reg(logic index, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[CfgWidth-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index == CfgRows)
            rows_reg = value & 7'h7f;
        else
            cols_reg = value & 7'h7f;
    endtask

    task automatic drain();
        wait (pending_cells.size() == 0 && expected_counts.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_cell(int unsigned r, int unsigned c);
        cell_req_t req;
        req.cell_row = r[5:0];
        req.cell_col = c[5:0];
        pending_cells = {pending_cells, req};
    endtask

    // random cells biased toward the active grid so islands grow and merge
    task automatic queue_random(int unsigned n);
        int unsigned rlim;
        int unsigned clim;
        rlim = rows_reg == 0 ? 1 : (rows_reg > GRID_MAX ? GRID_MAX : rows_reg);
        clim = cols_reg == 0 ? 1 : (cols_reg > GRID_MAX ? GRID_MAX : cols_reg);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                queue_cell($urandom_range(63), $urandom_range(63));
            else
                queue_cell($urandom_range(rlim - 1), $urandom_range(clim - 1));
        end
    endtask

    initial
    begin
        errors = 0;
        idle_off = 1'b0;
        out_hold = 1'b0;
        in_hold = 1'b0;
        rows_reg = 64;
        cols_reg = 64;
        island_count = 0;
        foreach (is_land[i])
        begin
            is_land[i] = 1'b0;
            link[i] = '0;
            set_size[i] = 0;
        end
        cfg_we = 1'b0;
        cfg_index = CfgRows;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, a repeat, a merge of four
        queue_cell(0, 0);
        queue_cell(63, 63);
        queue_cell(0, 63);
        queue_cell(63, 0);
        queue_cell(0, 0);
        queue_cell(5, 5);
        queue_cell(5, 7);
        queue_cell(4, 6);
        queue_cell(6, 6);
        queue_cell(5, 6);
        queue_cell(42, 21);
        queue_cell(21, 42);
        drain();

        // small grid, then out-of-range positions and stride change with land
        write_reg(CfgRows, 3);
        write_reg(CfgCols, 5);
        queue_cell(2, 4);
        queue_cell(3, 0);
        queue_cell(0, 5);
        queue_cell(1, 4);
        queue_cell(2, 3);
        drain();
        write_reg(CfgRows, 0);
        queue_cell(0, 0);
        drain();
        write_reg(CfgCols, 127);
        drain();
        write_reg(CfgRows, 127);
        queue_cell(1, 1);
        queue_cell(63, 62);
        drain();

        // receiver holds off long so the block stalls its input
        out_hold = 1'b1;
        queue_random(30);
        repeat (300) @(posedge clk);
        out_hold = 1'b0;
        drain();

        // random phases over several grid sizes
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin write_reg(CfgRows, 1); write_reg(CfgCols, 64); end
                1: begin write_reg(CfgRows, $urandom_range(2, 12));
                         write_reg(CfgCols, $urandom_range(2, 12)); end
                2: begin write_reg(CfgRows, 64); write_reg(CfgCols, 1); end
                default: begin write_reg(CfgRows, $urandom_range(1, 127));
                               write_reg(CfgCols, $urandom_range(1, 127)); end
            endcase
            idle_off = (p == 5);
            queue_random(250);
            // sender pauses until everything is back
            drain();
        end

        idle_off = 1'b0;
        drain();
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("testbench: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ogic_pkg.sv
rtl/core/ogic_ram.sv
rtl/core/online_grid_island_counter.sv
bench/testbench.sv
